[hw/rtl/sswg_pkg.sv]
// package for the segmented square wave generator: types, constants, codes
`timescale 1ns / 1ps
package sswg_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 16;
  localparam logic [15:0] TOP_RESET = 16'hFFFF;
  localparam logic [31:0] RATE_RESET = 32'd48000000;

  localparam logic CFG_IDX_TOP = 1'b0;
  localparam logic CFG_IDX_RATE = 1'b1;

  localparam logic CMD_MATCH = 1'b0;
  localparam logic CMD_SET = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [31:0] freq_fixed;
  } in_item_t;

  typedef struct packed {
    logic [15:0] match_value;
    logic        pin_level;
    logic        toggled;
    logic [1:0]  set_status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_QUOT,
    S_DIV_SEGS,
    S_DIV_BIG,
    S_DIV_TAIL,
    S_COMMIT,
    S_MATCH,
    S_MATCH_WAIT,
    S_EMIT
  } back_state_t;

endpackage

[hw/rtl/sswg_divider.sv]
// restoring serial divider, one quotient bit a cycle
`timescale 1ns / 1ps
module sswg_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [38:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [38:0] quotient,
  output logic [32:0] remainder
);

  logic [5:0]  count;
  logic        busy;
  logic [32:0] rem;
  logic [32:0] den;
  logic [34:0] trial;

  always_comb begin
    trial = {1'b0, rem, quotient[38]} - {2'b00, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && !start && (count == 6'd1);
      if (start) begin
        busy <= 1'b1;
        count <= 6'd39;
        rem <= '0;
        den <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        if (!trial[34]) begin
          rem <= trial[32:0];
          quotient <= {quotient[37:0], 1'b1};
        end else begin
          rem <= {rem[31:0], quotient[38]};
          quotient <= {quotient[37:0], 1'b0};
        end
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign remainder = rem;
endmodule

[hw/rtl/sswg_front.sv]
// input front: two-entry item queue towards the back part
`timescale 1ns / 1ps
module sswg_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  sswg_pkg::in_item_t item_in,
  output logic               q_valid,
  input  logic               q_take,
  output sswg_pkg::in_item_t q_item
);
  import sswg_pkg::*;

  in_item_t slot [2];
  logic     wr_ptr, rd_ptr;
  logic [1:0] fill;

  assign full = (fill == 2'd2);
  assign q_valid = (fill != 2'd0);
  assign q_item = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) slot[wr_ptr] <= item_in;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= '0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (q_take && q_valid) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push && !full} - {1'b0, q_take && q_valid};
    end
  end
endmodule

[hw/rtl/sswg_back.sv]
// back part: set computation and match stepping
`timescale 1ns / 1ps
module sswg_back #(
  parameter int COUNT_WIDTH = sswg_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         wrap_top,
  input  logic [31:0]         reference_rate,
  input  logic                q_valid,
  output logic                q_take,
  input  sswg_pkg::in_item_t  q_item,
  output logic                out_valid,
  input  logic                out_take,
  output sswg_pkg::out_item_t out_item
);
  import sswg_pkg::*;

  localparam logic [38:0] SEG_LIMIT = 39'((64'd1 << COUNT_WIDTH) - 64'd1);

  back_state_t state, state_next;
  logic [15:0] compare_value;
  logic        out_level, started, pending_valid;
  logic [COUNT_WIDTH-1:0] segments_left, active_big_count, pending_big_count;
  logic [15:0] active_big_step, active_tail_step;
  logic [15:0] pending_big_step, pending_tail_step;
  logic [31:0] cur_freq;
  logic [31:0] counts, segs, big, tail;
  logic [1:0]  status;
  logic        tog;

  logic        div_start, div_done;
  logic [38:0] div_a, div_q;
  logic [32:0] div_b, div_r;

  sswg_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a),
    .divisor(div_b), .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  logic        at_tail;
  logic [15:0] step_sel;
  logic        q_bad, segs_bad, tail_over;
  logic [31:0] counts_w, tail_w;
  logic [32:0] tail_excess, tail_fit;

  // tail is big plus the remainder of counts over segs plus one;
  // trimming keeps top + 1 - big plus the remainder of the excess over big
  always_comb begin
    at_tail = (segments_left == '0);
    step_sel = at_tail ? active_tail_step : active_big_step;
    q_bad = (div_q < 39'd2) || (div_q > 39'h1_0000_0000);
    counts_w = 32'(div_q - 39'd1);
    segs_bad = (div_q > SEG_LIMIT);
    tail_w = div_q[31:0] + div_r[31:0];
    tail_over = (tail_w > {16'd0, wrap_top});
    tail_excess = {1'b0, tail_w} - {17'd0, wrap_top} + {1'b0, div_q[31:0]} - 33'd1;
    tail_fit = {17'd0, wrap_top} + 33'd1 - {1'b0, big} + div_r;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_take = 1'b0;
    div_start = 1'b0;
    div_a = '0;
    div_b = '0;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_take = 1'b1;
          state_next = (q_item.cmd == CMD_SET) ? S_CHECK : S_MATCH;
        end
      end
      S_CHECK: begin
        if (pending_valid || cur_freq == '0 || wrap_top == '0) begin
          state_next = S_EMIT;
        end else begin
          div_start = 1'b1;
          div_a = {reference_rate, 7'd0};
          div_b = {1'b0, cur_freq};
          state_next = S_DIV_QUOT;
        end
      end
      S_DIV_QUOT: begin
        if (div_done) begin
          if (q_bad) begin
            state_next = S_EMIT;
          end else begin
            div_start = 1'b1;
            div_a = {7'd0, counts_w};
            div_b = {17'd0, wrap_top};
            state_next = S_DIV_SEGS;
          end
        end
      end
      S_DIV_SEGS: begin
        if (div_done) begin
          if (segs_bad) begin
            state_next = S_EMIT;
          end else begin
            div_start = 1'b1;
            div_a = {7'd0, counts};
            div_b = {1'b0, div_q[31:0]} + 33'd1;
            state_next = S_DIV_BIG;
          end
        end
      end
      S_DIV_BIG: begin
        if (div_done) begin
          if (tail_over && div_q[31:0] != '0) begin
            div_start = 1'b1;
            div_a = {6'd0, tail_excess};
            div_b = {1'b0, div_q[31:0]};
            state_next = S_DIV_TAIL;
          end else begin
            state_next = S_COMMIT;
          end
        end
      end
      S_DIV_TAIL: begin
        if (div_done) state_next = S_COMMIT;
      end
      S_COMMIT: state_next = S_EMIT;
      S_MATCH: begin
        if (!started) begin
          state_next = S_EMIT;
        end else begin
          div_start = 1'b1;
          div_a = {22'd0, {1'b0, compare_value} + {1'b0, step_sel}};
          div_b = {16'd0, {1'b0, wrap_top} + 17'd1};
          state_next = S_MATCH_WAIT;
        end
      end
      S_MATCH_WAIT: begin
        if (div_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || out_take) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      compare_value <= TOP_RESET;
      out_level <= 1'b0;
      started <= 1'b0;
      pending_valid <= 1'b0;
      segments_left <= '0;
      active_big_step <= '0;
      active_big_count <= '0;
      active_tail_step <= '0;
      pending_big_step <= '0;
      pending_big_count <= '0;
      pending_tail_step <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur_freq <= q_item.freq_fixed;
            status <= ST_OK;
            tog <= 1'b0;
          end
        end
        S_CHECK: begin
          if (pending_valid) status <= ST_BUSY;
          else if (cur_freq == '0 || wrap_top == '0) status <= ST_INVALID;
        end
        S_DIV_QUOT: begin
          if (div_done) begin
            if (q_bad) status <= ST_INVALID;
            counts <= counts_w;
          end
        end
        S_DIV_SEGS: begin
          if (div_done) begin
            if (segs_bad) status <= ST_INVALID;
            segs <= div_q[31:0];
          end
        end
        S_DIV_BIG: begin
          if (div_done) begin
            big <= div_q[31:0];
            // zero big step with an oversized tail saturates to the top
            if (tail_over && div_q[31:0] == '0) tail <= {16'd0, wrap_top};
            else tail <= tail_w;
          end
        end
        S_DIV_TAIL: begin
          if (div_done) tail <= {16'd0, tail_fit[15:0]};
        end
        S_COMMIT: begin
          pending_big_step <= big[15:0];
          pending_big_count <= segs[COUNT_WIDTH-1:0];
          pending_tail_step <= tail[15:0];
          pending_valid <= 1'b1;
          started <= 1'b1;
        end
        S_MATCH: begin
          if (started) begin
            if (!at_tail) begin
              segments_left <= segments_left - COUNT_WIDTH'(1);
            end else begin
              out_level <= ~out_level;
              tog <= 1'b1;
              if (pending_valid) begin
                active_big_step <= pending_big_step;
                active_big_count <= pending_big_count;
                active_tail_step <= pending_tail_step;
                pending_valid <= 1'b0;
                segments_left <= pending_big_count;
              end else begin
                segments_left <= active_big_count;
              end
            end
          end
        end
        S_MATCH_WAIT: begin
          if (div_done) compare_value <= div_r[15:0];
        end
        default: ;
      endcase
      if (state == S_EMIT && (!out_valid || out_take)) begin
        out_valid <= 1'b1;
        out_item.match_value <= compare_value;
        out_item.pin_level <= out_level;
        out_item.toggled <= tog;
        out_item.set_status <= status;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  p_emit_onlyfromemit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_EMIT)
    else $error("result raised outside emit");
  p_pending_set: assert property (@(posedge clk) disable iff (rst)
    $rose(pending_valid) |-> started)
    else $error("pending set without start");
  p_take_idle: assert property (@(posedge clk) disable iff (rst)
    q_take |-> state == S_IDLE)
    else $error("queue taken while busy");
  p_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_take |=> out_valid && $stable(out_item))
    else $error("waiting result changed");
endmodule

[hw/rtl/segmented_square_wave_generator.sv]
// top level of the segmented square wave generator
`timescale 1ns / 1ps
// a match event takes one serial divider pass once a set has been accepted, an accepted set
// takes three, or four when the tail needs trimming, and a rejected set at most two;
// throughput: one item at a time in the back part, the next taken the cycle after the
// previous result is loaded; two items wait in the front queue; reset: synchronous active
// high, compare value all ones, pin low, top 65535, rate 48000000, nothing pending
module segmented_square_wave_generator #(
  parameter int COUNT_WIDTH = sswg_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  sswg_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output sswg_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data
);
  import sswg_pkg::*;

  logic [15:0] wrap_top;
  logic [31:0] reference_rate;
  logic        q_valid, q_take, out_valid;
  in_item_t    q_item;

  // configuration always taken
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_top <= TOP_RESET;
      reference_rate <= RATE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_IDX_TOP) wrap_top <= cfg_data[15:0];
      else reference_rate <= cfg_data;
    end
  end

  sswg_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .item_in(in_item),
    .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
  );

  sswg_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk(clk), .rst(rst), .wrap_top(wrap_top), .reference_rate(reference_rate),
    .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
    .out_valid(out_valid), .out_take(pop), .out_item(out_item)
  );

  assign empty = ~out_valid;
endmodule

[sim/sswg_checker.sv]
// checker for the segmented square wave generator: tracks state, predicts and compares results
`timescale 1ns / 1ps
module sswg_checker #(
  parameter int COUNT_WIDTH = sswg_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                full,
  input  sswg_pkg::in_item_t  in_item,
  input  logic                empty,
  input  logic                pop,
  input  sswg_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data,
  output int                  fail_count
);
  import sswg_pkg::*;

  localparam logic [63:0] SEG_LIMIT = (64'd1 << COUNT_WIDTH) - 64'd1;

  logic [15:0] top_reg;
  logic [31:0] rate_reg;
  logic [15:0] cmp_val;
  logic        level;
  logic        running;
  logic [COUNT_WIDTH-1:0] segs_left;
  logic [15:0] act_big, act_tail, pend_big, pend_tail;
  logic [COUNT_WIDTH-1:0] act_cnt, pend_cnt;
  logic        pend_valid;
  out_item_t   results_due[$];

  function automatic void step_compare(logic [15:0] step);
    logic [63:0] modulus;
    modulus = {48'd0, top_reg} + 64'd1;
    cmp_val = 16'(({48'd0, cmp_val} + {48'd0, step}) % modulus);
  endfunction

  function automatic logic [1:0] apply_set(logic [31:0] freq);
    logic [63:0] q, counts, segs, big, tail, k, top64;
    if (pend_valid) return ST_BUSY;
    if (freq == 0 || top_reg == 0) return ST_INVALID;
    top64 = {48'd0, top_reg};
    q = ({32'd0, rate_reg} << 7) / {32'd0, freq};
    if (q < 2) return ST_INVALID;
    counts = q - 1;
    if (counts > 64'hFFFF_FFFF) return ST_INVALID;
    segs = counts / top64;
    if (segs > SEG_LIMIT) return ST_INVALID;
    big = counts / (segs + 1);
    tail = counts - big * segs;
    if (tail > top64) begin
      if (big == 0) begin
        tail = top64;
      end else begin
        k = (tail - top64 + big - 1) / big;
        tail = tail - k * big;
      end
    end
    pend_big = big[15:0];
    pend_cnt = segs[COUNT_WIDTH-1:0];
    pend_tail = tail[15:0];
    pend_valid = 1'b1;
    running = 1'b1;
    return ST_OK;
  endfunction

  // one result per item: the state after the item plus flags
  function automatic out_item_t predict_wave(in_item_t it);
    out_item_t r;
    r = '0;
    if (it.cmd == CMD_SET) begin
      r.set_status = apply_set(it.freq_fixed);
    end else if (running) begin
      if (segs_left != 0) begin
        step_compare(act_big);
        segs_left = segs_left - 1'b1;
      end else begin
        level = ~level;
        step_compare(act_tail);
        if (pend_valid) begin
          act_big = pend_big;
          act_cnt = pend_cnt;
          act_tail = pend_tail;
          pend_valid = 1'b0;
        end
        segs_left = act_cnt;
        r.toggled = 1'b1;
      end
    end
    r.match_value = cmp_val;
    r.pin_level = level;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      top_reg = TOP_RESET;
      rate_reg = RATE_RESET;
      cmp_val = TOP_RESET;
      level = 1'b0;
      running = 1'b0;
      segs_left = '0;
      act_big = '0;
      act_cnt = '0;
      act_tail = '0;
      pend_big = '0;
      pend_cnt = '0;
      pend_tail = '0;
      pend_valid = 1'b0;
      fail_count = 0;
      results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IDX_TOP) top_reg = cfg_data[15:0];
        else rate_reg = cfg_data;
      end
      if (push && !full) results_due.push_back(predict_wave(in_item));
      if (pop && !empty) begin
        if (results_due.size() == 0) begin
          $error("result with no item waiting");
          fail_count++;
        end else begin
          want = results_due.pop_front();
          if (out_item.match_value !== want.match_value) begin
            $error("match_value expected %0d got %0d", want.match_value, out_item.match_value);
            fail_count++;
          end
          if (out_item.pin_level !== want.pin_level) begin
            $error("pin_level expected %0d got %0d", want.pin_level, out_item.pin_level);
            fail_count++;
          end
          if (out_item.toggled !== want.toggled) begin
            $error("toggled expected %0d got %0d", want.toggled, out_item.toggled);
            fail_count++;
          end
          if (out_item.set_status !== want.set_status) begin
            $error("set_status expected %0d got %0d", want.set_status, out_item.set_status);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

[sim/segmented_square_wave_generator_test.sv]
// testbench top for the segmented square wave generator: stimulus, handshakes and verdict
`timescale 1ns / 1ps
module segmented_square_wave_generator_test;
  import sswg_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  in_item_t    in_item;
  logic        empty;
  logic        pop;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;
  int          fail_count;
  int          items_in, items_out, idle_cycles;
  logic [15:0] cur_top;
  logic [31:0] cur_rate;
  int          burst_left;

  segmented_square_wave_generator dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sswg_checker checker_i (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // count accepted items both ways; the watchdog trips when nothing moves for too long
  always @(posedge clk) begin
    if (rst) begin
      items_in <= 0;
      items_out <= 0;
      idle_cycles <= 0;
    end else begin
      if (push && !full) items_in <= items_in + 1;
      if (pop && !empty) items_out <= items_out + 1;
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver: random stalls, with calm stretches where it always pops
  int stall_left;
  int calm_left;
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      stall_left <= 0;
      calm_left <= 0;
    end else if (calm_left > 0) begin
      pop <= 1'b1;
      calm_left <= calm_left - 1;
    end else if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      pop <= 1'b1;
      case ($urandom_range(0, 19))
        0: calm_left <= $urandom_range(50, 300);
        1, 2, 3: stall_left <= $urandom_range(1, 15);
        default: ;
      endcase
    end
  end

  task automatic write_reg(logic idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_IDX_TOP) cur_top = value[15:0];
    else cur_rate = value;
  endtask

  // push one item; push stays high across a burst and drops only for a gap
  task automatic send_item(logic cmd, logic [31:0] freq);
    int gap;
    push <= 1'b1;
    in_item <= '{cmd: cmd, freq_fixed: freq};
    do @(posedge clk); while (full);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop sending, wait for every result, then let the back end settle before touching registers
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (items_out != items_in) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // frequency that gives roughly a chosen number of big segments per half period
  function automatic logic [31:0] freq_for_segments(int segs);
    logic [63:0] span, f;
    span = ({48'd0, cur_top} + 64'd1) * 64'(segs);
    f = ({32'd0, cur_rate} << 7) / (span + 64'd1);
    f = f + 64'($urandom_range(0, 3)) - 64'd1;
    if (f > 64'hFFFF_FFFF) f = 64'hFFFF_FFFF;
    return f[31:0];
  endfunction

  task automatic random_phase(int n);
    int i;
    logic [31:0] f;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 5))
          0: f = $urandom;
          1: f = $urandom_range(0, 3);
          default: f = freq_for_segments($urandom_range(1, 4));
        endcase
        send_item(CMD_SET, f);
      end else begin
        // match items carry noise in the unused field too
        send_item(CMD_MATCH, $urandom);
      end
    end
  endtask

  initial begin
    logic [15:0] tops[6];
    logic [31:0] rates[6];
    int p;
    rst = 1'b1;
    push = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_IDX_TOP;
    cfg_data = '0;
    cur_top = TOP_RESET;
    cur_rate = RATE_RESET;
    burst_left = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: not started, zero frequency, extremes, busy, wrap of the compare
    send_item(CMD_MATCH, 32'd0);
    send_item(CMD_SET, 32'd0);
    send_item(CMD_SET, 32'd1);
    send_item(CMD_SET, 32'hFFFF_FFFF);
    send_item(CMD_MATCH, 32'hFFFF_FFFF);
    send_item(CMD_SET, 32'd60000);
    send_item(CMD_SET, 32'd60000);
    repeat (6) send_item(CMD_MATCH, 32'd0);
    send_item(CMD_SET, 32'd6000);
    repeat (10) send_item(CMD_MATCH, 32'd0);
    drain();

    // lowering the top below the compare value, then zero rate and zero top
    write_reg(CFG_IDX_TOP, 32'd7);
    write_reg(CFG_IDX_RATE, 32'd0);
    send_item(CMD_MATCH, 32'd0);
    send_item(CMD_SET, 32'd5);
    drain();
    write_reg(CFG_IDX_TOP, 32'd0);
    write_reg(CFG_IDX_RATE, 32'd1000);
    send_item(CMD_SET, 32'd5);
    send_item(CMD_MATCH, 32'd0);
    drain();

    tops  = '{16'd65535, 16'd1, 16'd300, 16'd65535, 16'd1000, 16'd40};
    rates = '{32'd48000000, 32'd1, 32'd1000, 32'hFFFF_FFFF, 32'd12345678, 32'd777};
    for (p = 0; p < 6; p++) begin
      write_reg(CFG_IDX_TOP, {16'd0, tops[p]});
      write_reg(CFG_IDX_RATE, rates[p]);
      random_phase(200);
      drain();
    end

    push <= 1'b0;
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/sswg_pkg.sv
hw/rtl/sswg_divider.sv
hw/rtl/sswg_front.sv
hw/rtl/sswg_back.sv
hw/rtl/segmented_square_wave_generator.sv
sim/sswg_checker.sv
sim/segmented_square_wave_generator_test.sv
